>>> hw/rtl/smv_pkg.sv
package smv_pkg;

  // Field and accumulator widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned MEAN_W    = 16;
  localparam int unsigned VAR_W     = 31;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned SUM_W     = 28;
  localparam int unsigned SQSUM_W   = 43;
  localparam int unsigned ACC_W     = 56;
  localparam int unsigned CNT_W     = 6;

  localparam int unsigned MAX_COUNT = 4096;

  // Last step index of each iterative phase
  localparam logic [CNT_W-1:0] SQR_LAST  = CNT_W'(SAMPLE_W - 1);
  localparam logic [CNT_W-1:0] NMUL_LAST = CNT_W'(COUNT_W - 1);
  localparam logic [CNT_W-1:0] SMUL_LAST = CNT_W'(SUM_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(ACC_W - 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } smv_in_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
    logic [COUNT_W-1:0]       sample_count;
    logic                     overflow;
  } smv_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_SQR,
    ST_MEAN_LD,
    ST_MEAN_DIV,
    ST_NMUL_LD,
    ST_NMUL,
    ST_SMUL_LD,
    ST_SMUL,
    ST_VDIV1_LD,
    ST_VDIV1,
    ST_VDIV2_LD,
    ST_VDIV2,
    ST_EMIT
  } state_e;

  // What the shared adder does this cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SUM,
    OP_MAC,
    OP_MADD,
    OP_MSUB,
    OP_DIV
  } op_e;

  // Operand register loads between phases
  typedef enum logic [2:0] {
    LD_NONE,
    LD_SQR,
    LD_MEAN,
    LD_NMUL,
    LD_SMUL,
    LD_VDIV1,
    LD_VDIV2
  } ld_e;

  typedef struct packed {
    op_e  op;
    ld_e  load;
    logic emit;
    logic busy;
  } ctl_t;

endpackage

>>> hw/rtl/smv_alu.sv
module smv_alu
  import smv_pkg::*;
(
  input  logic [ACC_W-1:0] x_i,
  input  logic [ACC_W-1:0] y_i,
  input  logic             sub_i,
  output logic [ACC_W-1:0] sum_o,
  output logic             carry_o
);

  logic [ACC_W-1:0] y_inv;
  logic [ACC_W:0]   total;

  // Shared add/subtract; carry out set means x >= y on a subtract
  assign y_inv = sub_i ? ~y_i : y_i;
  assign total = {1'b0, x_i} + {1'b0, y_inv} + (ACC_W + 1)'(sub_i);

  assign sum_o   = total[ACC_W-1:0];
  assign carry_o = total[ACC_W];

endmodule

>>> hw/rtl/smv_ctrl.sv
module smv_ctrl
  import smv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic last_i,
  input  logic full_i,
  output ctl_t ctl_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last_q, last_d;
  logic             cnt_zero;

  assign cnt_zero = (cnt_q == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (!full_i)     state_d = ST_SUM;
          else if (last_i) state_d = ST_MEAN_LD;
        end
      end
      ST_SUM:      state_d = ST_SQR;
      ST_SQR: begin
        if (cnt_zero) state_d = last_q ? ST_MEAN_LD : ST_IDLE;
      end
      ST_MEAN_LD:  state_d = ST_MEAN_DIV;
      ST_MEAN_DIV: if (cnt_zero) state_d = ST_NMUL_LD;
      ST_NMUL_LD:  state_d = ST_NMUL;
      ST_NMUL:     if (cnt_zero) state_d = ST_SMUL_LD;
      ST_SMUL_LD:  state_d = ST_SMUL;
      ST_SMUL:     if (cnt_zero) state_d = ST_VDIV1_LD;
      ST_VDIV1_LD: state_d = ST_VDIV1;
      ST_VDIV1:    if (cnt_zero) state_d = ST_VDIV2_LD;
      ST_VDIV2_LD: state_d = ST_VDIV2;
      ST_VDIV2:    if (cnt_zero) state_d = ST_EMIT;
      ST_EMIT:     state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs and step counter
  always_comb begin
    ctl_o.op   = OP_NONE;
    ctl_o.load = LD_NONE;
    ctl_o.emit = 1'b0;
    ctl_o.busy = 1'b1;
    cnt_d      = cnt_q - CNT_W'(1);
    last_d     = last_q;
    unique case (state_q)
      ST_IDLE: begin
        ctl_o.busy = 1'b0;
        cnt_d      = cnt_q;
        if (start_i) last_d = last_i;
      end
      ST_SUM: begin
        ctl_o.op   = OP_SUM;
        ctl_o.load = LD_SQR;
        cnt_d      = SQR_LAST;
      end
      ST_SQR:      ctl_o.op = OP_MAC;
      ST_MEAN_LD: begin
        ctl_o.load = LD_MEAN;
        cnt_d      = DIV_LAST;
      end
      ST_MEAN_DIV: ctl_o.op = OP_DIV;
      ST_NMUL_LD: begin
        ctl_o.load = LD_NMUL;
        cnt_d      = NMUL_LAST;
      end
      ST_NMUL:     ctl_o.op = OP_MADD;
      ST_SMUL_LD: begin
        ctl_o.load = LD_SMUL;
        cnt_d      = SMUL_LAST;
      end
      ST_SMUL:     ctl_o.op = OP_MSUB;
      ST_VDIV1_LD: begin
        ctl_o.load = LD_VDIV1;
        cnt_d      = DIV_LAST;
      end
      ST_VDIV1:    ctl_o.op = OP_DIV;
      ST_VDIV2_LD: begin
        ctl_o.load = LD_VDIV2;
        cnt_d      = DIV_LAST;
      end
      ST_VDIV2:    ctl_o.op = OP_DIV;
      ST_EMIT: begin
        ctl_o.emit = 1'b1;
        last_d     = 1'b0;
        cnt_d      = cnt_q;
      end
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
    end
  end

endmodule

>>> hw/rtl/streaming_mean_variance.sv
// Streaming mean and population variance over sets of signed Q8.8 samples.
// A sample beat is taken when start_i is high while busy_o is low. An ordinary
// sample keeps busy_o high for one add, then a 16-step shift-add square into
// the sum of squares; a sample that arrives with the set already holding 4096
// samples is dropped in its accept cycle and flags overflow. The beat with
// last set also runs the closing sequence on the same shared 56-bit adder: a
// 56-step divide for the mean, a 13-step and a 28-step multiply for
// N*sumsq - sum^2, and two 56-step divides by N. The result is presented on
// out_o for exactly one cycle with done_o high and cannot be held off, so the
// receiver must capture it then. State is cleared after each result.
module streaming_mean_variance
  import smv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  smv_in_t  in_i,
  output logic     busy_o,
  output logic     done_o,
  output smv_out_t out_o
);

  ctl_t ctl;

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SQSUM_W-1:0]      sumsq_q, sumsq_d;
  logic [COUNT_W-1:0]      count_q, count_d;
  logic                    ovf_q, ovf_d;
  logic [SAMPLE_W-1:0]     sample_q;
  logic [MEAN_W-1:0]       mean_q;
  logic [ACC_W-1:0]        a_q, a_d;
  logic [ACC_W-1:0]        b_q, b_d;
  logic [ACC_W-1:0]        c_q, c_d;
  smv_out_t                res_q;
  logic                    done_q;

  logic                    accept;
  logic                    full;
  logic [SAMPLE_W-1:0]     mag;
  logic [SUM_W-1:0]        smag;
  logic [ACC_W-1:0]        alu_x, alu_y, alu_sum, mac_y, rem_shift;
  logic                    alu_sub, alu_carry;
  logic [MEAN_W-1:0]       quot_lo;

  smv_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .last_i  (in_i.last),
    .full_i  (full),
    .ctl_o   (ctl)
  );

  smv_alu u_alu (
    .x_i     (alu_x),
    .y_i     (alu_y),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  assign busy_o = ctl.busy;
  assign accept = start_i & ~ctl.busy;
  assign full   = (count_q == COUNT_W'(MAX_COUNT));

  // Magnitudes; the most negative value maps to its unsigned magnitude
  assign mag  = sample_q[SAMPLE_W-1] ? (~sample_q + SAMPLE_W'(1)) : sample_q;
  assign smag = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;

  assign mac_y     = c_q[0] ? b_q : '0;
  assign rem_shift = {a_q[ACC_W-2:0], c_q[ACC_W-1]};
  assign quot_lo   = c_q[MEAN_W-1:0];

  // Operand select for the shared adder
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    unique case (ctl.op)
      OP_NONE: ;
      OP_SUM: begin
        alu_x = ACC_W'(sum_q);
        alu_y = ACC_W'($signed(sample_q));
      end
      OP_MAC: begin
        alu_x = ACC_W'(sumsq_q);
        alu_y = mac_y;
      end
      OP_MADD: begin
        alu_x = a_q;
        alu_y = mac_y;
      end
      OP_MSUB: begin
        alu_x   = a_q;
        alu_y   = mac_y;
        alu_sub = 1'b1;
      end
      OP_DIV: begin
        alu_x   = rem_shift;
        alu_y   = b_q;
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  // Accumulators and working registers
  always_comb begin
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;

    if (accept && full) ovf_d = 1'b1;

    unique case (ctl.op)
      OP_NONE: ;
      OP_SUM: begin
        sum_d   = alu_sum[SUM_W-1:0];
        count_d = count_q + COUNT_W'(1);
      end
      OP_MAC: begin
        sumsq_d = alu_sum[SQSUM_W-1:0];
        b_d     = {b_q[ACC_W-2:0], 1'b0};
        c_d     = {1'b0, c_q[ACC_W-1:1]};
      end
      OP_MADD, OP_MSUB: begin
        a_d = alu_sum;
        b_d = {b_q[ACC_W-2:0], 1'b0};
        c_d = {1'b0, c_q[ACC_W-1:1]};
      end
      OP_DIV: begin
        // restoring divide step: keep the difference when it does not borrow
        a_d = alu_carry ? alu_sum : rem_shift;
        c_d = {c_q[ACC_W-2:0], alu_carry};
      end
      default: ;
    endcase

    unique case (ctl.load)
      LD_NONE: ;
      LD_SQR: begin
        b_d = ACC_W'(mag);
        c_d = ACC_W'(mag);
      end
      LD_MEAN: begin
        a_d = '0;
        b_d = ACC_W'(count_q);
        c_d = ACC_W'(smag);
      end
      LD_NMUL: begin
        a_d = '0;
        b_d = ACC_W'(sumsq_q);
        c_d = ACC_W'(count_q);
      end
      LD_SMUL: begin
        b_d = ACC_W'(smag);
        c_d = ACC_W'(smag);
      end
      LD_VDIV1: begin
        a_d = '0;
        b_d = ACC_W'(count_q);
        c_d = a_q;
      end
      LD_VDIV2: a_d = '0;
      default: ;
    endcase

    if (ctl.emit) begin
      sum_d   = '0;
      sumsq_d = '0;
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sumsq_q <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      sumsq_q <= sumsq_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      done_q  <= ctl.emit;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    if (accept) sample_q <= in_i.sample;
    // mean quotient is in c_q when the first multiply is set up
    if (ctl.load == LD_NMUL) begin
      mean_q <= sum_q[SUM_W-1] ? (~quot_lo + MEAN_W'(1)) : quot_lo;
    end
    if (ctl.emit) begin
      res_q.mean         <= mean_q;
      res_q.variance     <= (c_q[ACC_W-1:VAR_W] != '0) ? {VAR_W{1'b1}} : c_q[VAR_W-1:0];
      res_q.sample_count <= count_q;
      res_q.overflow     <= ovf_q;
    end
  end

  assign done_o = done_q;
  assign out_o  = res_q;

endmodule

>>> tb/tb_streaming_mean_variance.sv
module tb_streaming_mean_variance;
  timeunit 1ns;
  timeprecision 1ps;

  import smv_pkg::*;

  localparam int     NUM_DIRECTED  = 24;
  localparam int     RANDOM_BEATS  = 1930;
  localparam int     IDLE_LIMIT    = 4000;
  localparam int     DRAIN_CYCLES  = 300;
  localparam longint VAR_CEIL      = (longint'(1) << VAR_W) - 1;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  smv_in_t  in_i;
  logic     busy_o;
  logic     done_o;
  smv_out_t out_o;

  streaming_mean_variance uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .in_i    (in_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .out_o   (out_o)
  );

  // Directed row: one sample beat, with the set statistics typed in where obvious
  typedef struct {
    int     sample;
    bit     last;
    bit     typed;
    int     mean;
    longint variance;
    int     count;
    bit     overflow;
  } sample_row_t;

  sample_row_t sample_rows [NUM_DIRECTED] = '{
    // single-sample sets: mean is the sample, variance zero
    '{0,      1, 1, 0,      0,     1, 0},
    '{-32768, 1, 1, -32768, 0,     1, 0},
    '{32767,  1, 1, 32767,  0,     1, 0},
    '{256,    1, 1, 256,    0,     1, 0},
    '{-1,     1, 1, -1,     0,     1, 0},
    // opposite extremes: largest spread
    '{-32768, 0, 0, 0,      0,     0, 0},
    '{32767,  1, 0, 0,      0,     0, 0},
    // negative mean truncates toward zero
    '{-3,     0, 0, 0,      0,     0, 0},
    '{0,      1, 0, 0,      0,     0, 0},
    '{1,      0, 0, 0,      0,     0, 0},
    '{1,      0, 0, 0,      0,     0, 0},
    '{1,      0, 0, 0,      0,     0, 0},
    '{-32768, 1, 0, 0,      0,     0, 0},
    // constant set at the top of the range
    '{32767,  0, 0, 0,      0,     0, 0},
    '{32767,  0, 0, 0,      0,     0, 0},
    '{32767,  0, 0, 0,      0,     0, 0},
    '{32767,  1, 1, 32767,  0,     4, 0},
    // +/- one unit: mean zero, variance one unit squared
    '{-256,   0, 0, 0,      0,     0, 0},
    '{256,    0, 0, 0,      0,     0, 0},
    '{-256,   0, 0, 0,      0,     0, 0},
    '{256,    1, 1, 0,      65536, 4, 0},
    // alternating bit patterns
    '{21845,  0, 0, 0,      0,     0, 0},
    '{-21846, 0, 0, 0,      0,     0, 0},
    '{-21846, 1, 0, 0,      0,     0, 0}
  };

  // Running set statistics of the predictor
  longint acc_sum;
  longint acc_sqsum;
  int     acc_count;
  bit     acc_dropped;

  smv_out_t stats_due [$];
  int       mismatches;
  int       idle_cycles;
  int       burst_left;

  // Fold one accepted sample into the set; on the closing beat return the
  // set statistics and clear for the next set
  function automatic smv_out_t fold_sample(smv_in_t beat);
    longint   value;
    longint   n;
    longint   quotient;
    longint   spread;
    smv_out_t stats;
    value    = longint'($signed(beat.sample));
    quotient = 0;
    spread   = 0;
    stats    = '0;
    if (acc_count < MAX_COUNT) begin
      acc_sum   += value;
      acc_sqsum += value * value;
      acc_count++;
    end else begin
      acc_dropped = 1'b1;
    end
    if (beat.last) begin
      n = acc_count;
      if (n != 0) begin
        // SV division truncates toward zero
        quotient = acc_sum / n;
        spread   = (n * acc_sqsum - acc_sum * acc_sum) / (n * n);
        if (spread > VAR_CEIL) spread = VAR_CEIL;
      end
      stats.mean         = MEAN_W'(quotient);
      stats.variance     = VAR_W'(spread);
      stats.sample_count = COUNT_W'(n);
      stats.overflow     = acc_dropped;
      acc_sum     = 0;
      acc_sqsum   = 0;
      acc_count   = 0;
      acc_dropped = 1'b0;
    end
    return stats;
  endfunction

  // Mostly full-range, with extremes and small values mixed in
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] value;
    case ($urandom_range(0, 9))
      0:       value = SAMPLE_W'(16'h8000);
      1:       value = SAMPLE_W'(16'h7fff);
      2, 3:    value = SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
      default: value = SAMPLE_W'($urandom);
    endcase
    return value;
  endfunction

  // Sender idling: bursts of random length, random gaps in between
  task automatic sender_pause(input bit quick);
    int          gap;
    smv_in_t     junk;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if (quick) begin
        burst_left = $urandom_range(50, 300);
        gap        = $urandom_range(1, 3);
      end else begin
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 10);
        gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 260)
                                                 : $urandom_range(1, 12);
      end
      junk.sample = SAMPLE_W'($urandom);
      junk.last   = 1'($urandom);
      @(negedge clk_i);
      start_i <= 1'b0;
      in_i    <= junk;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Drive one sample beat and hold it until the block takes it
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic closing,
                             input bit typed, input smv_out_t typed_stats);
    smv_in_t  beat;
    smv_out_t predicted;
    beat.sample = value;
    beat.last   = closing;
    @(negedge clk_i);
    start_i <= 1'b1;
    in_i    <= beat;
    do @(posedge clk_i); while (busy_o);
    predicted = fold_sample(beat);
    if (closing) stats_due.push_back(typed ? typed_stats : predicted);
  endtask

  task automatic check_stats(smv_out_t got);
    smv_out_t want;
    if (stats_due.size() == 0) begin
      $error("unexpected result: mean %0d variance %0d count %0d overflow %0d",
             $signed(got.mean), got.variance, got.sample_count, got.overflow);
      mismatches++;
    end else begin
      want = stats_due.pop_front();
      if (got.mean !== want.mean) begin
        $error("mean: expected %0d, got %0d", $signed(want.mean), $signed(got.mean));
        mismatches++;
      end
      if (got.variance !== want.variance) begin
        $error("variance: expected %0d, got %0d", want.variance, got.variance);
        mismatches++;
      end
      if (got.sample_count !== want.sample_count) begin
        $error("sample_count: expected %0d, got %0d", want.sample_count,
               got.sample_count);
        mismatches++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
        mismatches++;
      end
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result checking
  always @(posedge clk_i) begin
    if (rst_ni && done_o) check_stats(out_o);
  end

  // Watchdog: cycles with neither a sample beat nor a result
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("streaming_mean_variance regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    smv_out_t    typed_stats;
    sample_row_t row;
    int          random_beats;
    int          set_len;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    in_i        = '0;
    acc_sum     = 0;
    acc_sqsum   = 0;
    acc_count   = 0;
    acc_dropped = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    burst_left  = 0;
    random_beats = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (sample_rows[i]) begin
      row = sample_rows[i];
      typed_stats.mean         = MEAN_W'(row.mean);
      typed_stats.variance     = VAR_W'(row.variance);
      typed_stats.sample_count = COUNT_W'(row.count);
      typed_stats.overflow     = row.overflow;
      send_sample(SAMPLE_W'(row.sample), row.last, row.typed, typed_stats);
      sender_pause(1'b0);
    end

    // Set filled exactly to capacity
    for (int i = 0; i < MAX_COUNT; i++) begin
      send_sample(pick_sample(), i == MAX_COUNT - 1, 1'b0, '0);
      sender_pause(1'b1);
    end
    // Overfilled set: extra samples dropped, the closing one too
    for (int i = 0; i < MAX_COUNT + 3; i++) begin
      send_sample(pick_sample(), i == MAX_COUNT + 2, 1'b0, '0);
      sender_pause(1'b1);
    end

    // Random sets, mostly short
    while (random_beats < RANDOM_BEATS) begin
      case ($urandom_range(0, 19))
        0:          set_len = $urandom_range(33, 200);
        1, 2, 3, 4: set_len = 1;
        default:    set_len = $urandom_range(2, 32);
      endcase
      for (int i = 0; i < set_len; i++) begin
        send_sample(pick_sample(), i == set_len - 1, 1'b0, '0);
        random_beats++;
        sender_pause(1'b0);
      end
    end

    // Drain
    @(negedge clk_i);
    start_i <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("streaming_mean_variance regression: pass");
    end else begin
      $display("streaming_mean_variance regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/smv_pkg.sv
hw/rtl/smv_alu.sv
hw/rtl/smv_ctrl.sv
hw/rtl/streaming_mean_variance.sv
tb/tb_streaming_mean_variance.sv
